FILE: rtl/core/ist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants for the ID set table
// Request and result layouts, opcodes, sequencer states, default sizes.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 16;
  localparam int ID_IN_W      = 16;
  localparam int INDEX_W      = 4;
  localparam int COUNT_W      = 5;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_READ     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [ID_IN_W-1:0]   id_value;
    logic [INDEX_W-1:0]   index;
  } in_item_t;

  typedef struct packed {
    logic                 status;
    logic                 found;
    logic [ID_IN_W-1:0]   id_out;
    logic [COUNT_W-1:0]   count;
    logic                 empty_res;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/ist_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ist_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ist_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ist_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ist_seq: request sequencer for the ID set table
// Scans the entry RAM, appends, closes gaps on remove, reads by index, keeps the count.
// ----------------------------------------------------------------------------
module ist_seq #(
  parameter int DEPTH    = ist_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = ist_pkg::ID_WIDTH_DEF,
  parameter int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request side
  input  wire logic                 req_valid,
  input  wire ist_pkg::in_item_t    req_item,
  output logic                      idle,
  // result side
  output logic                      res_valid,
  input  wire logic                 res_ack,
  output ist_pkg::out_item_t        res_item,
  // entry RAM
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [ID_WIDTH-1:0]       wr_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  wire logic [ID_WIDTH-1:0]  rd_data
);

  import ist_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t                state_r, state_nxt;
  opcode_t               op_r, op_nxt;
  logic [ID_WIDTH-1:0]   id_r, id_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         iss_r, iss_nxt;     // next entry to read
  logic                  rv_r, rv_nxt;       // read data due this cycle
  logic [CW-1:0]         rptr_r, rptr_nxt;   // entry that data belongs to
  logic                  status_r, status_nxt;
  logic                  found_r, found_nxt;
  logic [ID_IN_W-1:0]    idout_r, idout_nxt;

  logic [63:0]           id_in_wide;
  logic [ID_WIDTH-1:0]   id_in;
  logic [31:0]           idx_wide;
  logic [63:0]           rd_wide;
  logic [31:0]           count_wide;
  logic [CW-1:0]         wr_ptr;
  logic                  hit;
  logic                  scan_end;

  assign id_in_wide = 64'(req_item.id_value);
  assign id_in      = id_in_wide[ID_WIDTH-1:0];
  assign idx_wide   = 32'(req_item.index);
  assign rd_wide    = 64'(rd_data);
  assign count_wide = 32'(count_r);
  assign wr_ptr     = rptr_r - CW'(1);
  assign hit        = rv_r && (rd_data == id_r);
  assign scan_end   = (iss_r == count_r) && !rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    iss_r    <= iss_nxt;
    rptr_r   <= rptr_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    idout_r  <= idout_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    id_nxt     = id_r;
    count_nxt  = count_r;
    iss_nxt    = iss_r;
    rv_nxt     = rv_r;
    rptr_nxt   = rptr_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    idout_nxt  = idout_r;
    rd_en      = 1'b0;
    rd_addr    = iss_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = count_r[AW-1:0];
    wr_data    = id_r;

    case (state_r)
      ST_IDLE: begin
        rv_nxt = 1'b0;
        if (req_valid) begin
          op_nxt     = req_item.opcode;
          id_nxt     = id_in;
          iss_nxt    = '0;
          status_nxt = 1'b0;
          found_nxt  = 1'b0;
          idout_nxt  = '0;
          if (req_item.opcode == OP_READ) begin
            if (idx_wide < count_wide) begin
              rd_en     = 1'b1;
              rd_addr   = idx_wide[AW-1:0];
              state_nxt = ST_RDWAIT;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          case (op_r)
            OP_REMOVE: begin
              iss_nxt   = rptr_r + CW'(1);
              rv_nxt    = 1'b0;
              state_nxt = ST_SHIFT;
            end
            OP_CONTAINS: begin
              found_nxt = 1'b1;
              state_nxt = ST_DONE;
            end
            default: begin
              // duplicate add
              status_nxt = 1'b1;
              state_nxt  = ST_DONE;
            end
          endcase
        end else if (scan_end) begin
          state_nxt = ST_DONE;
          case (op_r)
            OP_ADD: begin
              if ((id_r == '0) || (count_wide == 32'(DEPTH))) begin
                status_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REMOVE: begin
              status_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end else if (iss_r != count_r) begin
          rd_en    = 1'b1;
          iss_nxt  = iss_r + CW'(1);
          rptr_nxt = iss_r;
          rv_nxt   = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
      end

      ST_SHIFT: begin
        // each entry moves down one place, one read and one write a cycle
        if (rv_r) begin
          wr_en   = 1'b1;
          wr_addr = wr_ptr[AW-1:0];
          wr_data = rd_data;
        end
        if (iss_r != count_r) begin
          rd_en    = 1'b1;
          iss_nxt  = iss_r + CW'(1);
          rptr_nxt = iss_r;
          rv_nxt   = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (scan_end) begin
          count_nxt = count_r - CW'(1);
          state_nxt = ST_DONE;
        end
      end

      ST_RDWAIT: begin
        idout_nxt = rd_wide[ID_IN_W-1:0];
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (res_ack) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign idle               = (state_r == ST_IDLE);
  assign res_valid          = (state_r == ST_DONE);
  assign res_item.status    = status_r;
  assign res_item.found     = found_r;
  assign res_item.id_out    = idout_r;
  assign res_item.count     = count_wide[COUNT_W-1:0];
  assign res_item.empty_res = (count_r == '0);

endmodule

`default_nettype wire

FILE: rtl/core/id_set_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id_set_table: ordered set of nonzero IDs with membership and count
// Add, remove, contains and indexed read over an entry RAM, one result each.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  in_       in         in_valid / in_stall  in_item  (opcode, id_value, index)
//  out_      out        out_valid/ out_stall out_item (status, found, id_out,
//                                                      count, empty_res)
//
// One request at a time. Read issues the RAM read on transfer and takes the
// data in ST_RDWAIT. Add and contains scan the entry RAM one entry a cycle;
// a contains hit ends the scan early.
// Remove scans to the match, then moves each later entry down one place a
// cycle through the same RAM ports.
// Reset clears the count, not the entries; entries at or above the count are never read.
// The result register frees the sequencer, so the next request is taken
// while a result is still stalled at the output.
//
module id_set_table #(
  parameter int DEPTH    = ist_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = ist_pkg::ID_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ist_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ist_pkg::out_item_t       out_item
);

  import ist_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer <-> RAM
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ID_WIDTH-1:0] wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [ID_WIDTH-1:0] rd_data;

  // sequencer <-> output register
  logic       seq_idle;
  logic       res_valid;
  logic       res_ack;
  out_item_t  res_item;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;

  ist_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ist_seq #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH),
    .AW       (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_item  (in_item),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_ack   (res_ack),
    .res_item  (res_item),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Input side: a transfer only lands on an idle sequencer.
  assign in_stall = !seq_idle;

  // Result moves into the output register once that register is free or
  // being emptied this cycle.
  assign res_ack = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ack) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A taken request always leaves the sequencer busy in the cycle after the transfer.
  a_busy_after_transfer : assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("request transfer did not occupy the sequencer");

  // Empty flag tracks the reported count.
  a_empty_matches_count : assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.empty_res == (out_item.count == '0))
  ) else $error("empty flag disagrees with count");

  // A membership hit is never an error and never carries read data.
  a_found_clean : assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found) |-> (!out_item.status && (out_item.id_out == '0))
  ) else $error("found result carries error or read data");

endmodule

`default_nettype wire
